// File: src/assert_macros.svh
// Assertion macros shared by the cubic Bezier evaluator RTL.
// No dependencies; each user must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define CBPE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define CBPE_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: src/cbpe_pkg.sv
// Package for the cubic Bezier evaluator: widths, register codes, point
// struct and the fixed-point interpolation function. No dependencies.
package cbpe_pkg;

  localparam int COORD_BITS  = 10;
  localparam int T_FRAC_BITS = 16;
  localparam int T_W         = T_FRAC_BITS + 1;
  localparam int FIX_W       = COORD_BITS + T_FRAC_BITS;
  localparam int PROD_W      = T_W + 1 + FIX_W + 1;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
    REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y
  } cbpe_reg_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FIX_W-1:0]      fix_t;

  typedef struct packed {
    logic [3:0][COORD_BITS-1:0] x;
    logic [3:0][COORD_BITS-1:0] y;
  } cbpe_points_t;

  // Pixel coordinate to fixed point.
  function automatic fix_t to_fix(input coord_t c);
    return {c, {T_FRAC_BITS{1'b0}}};
  endfunction

  // a + floor(t * (b - a) / ONE); the arithmetic shift floors both signs.
  function automatic fix_t lerp_fix(input fix_t a, input fix_t b,
                                    input logic [T_W-1:0] t);
    logic signed [FIX_W:0]    diff;
    logic signed [T_W:0]      ts;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum;
    diff = signed'({1'b0, b}) - signed'({1'b0, a});
    ts   = signed'({1'b0, t});
    prod = ts * diff;
    sum  = (prod >>> T_FRAC_BITS) + signed'(PROD_W'(a));
    return sum[FIX_W-1:0];
  endfunction

endpackage

// File: src/cbpe_regs.sv
// APB-style control register file holding the four control points.
// Depends on cbpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbpe_regs
  import cbpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cbpe_points_t      pts
);

  logic [NUM_REGS-1:0][COORD_BITS-1:0] regs;
  logic                                wr_en;
  logic [REG_IDX_W-1:0]                idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      regs[idx] <= pwdata[COORD_BITS-1:0];
    end
  end

  assign prdata = DATA_W'(regs[idx]);

  assign pts.x[0] = regs[REG_P0_X];
  assign pts.y[0] = regs[REG_P0_Y];
  assign pts.x[1] = regs[REG_P1_X];
  assign pts.y[1] = regs[REG_P1_Y];
  assign pts.x[2] = regs[REG_P2_X];
  assign pts.y[2] = regs[REG_P2_Y];
  assign pts.x[3] = regs[REG_P3_X];
  assign pts.y[3] = regs[REG_P3_Y];

  `CBPE_ASSERT(a_p3y_write, (wr_en && idx == REG_P3_Y) |=> (pts.y[3] == $past(pwdata[COORD_BITS-1:0])), "p3_y write not stored")

endmodule

// File: src/cbpe_pipe.sv
// Three-stage de Casteljau pipeline, one interpolation level per stage,
// with valid/ready flow control. Depends on cbpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbpe_pipe
  import cbpe_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cbpe_points_t    pts,
  input  logic            item_valid,
  output logic            item_ready,
  input  logic [T_W-1:0]  t_param,
  output logic            result_valid,
  input  logic            result_ready,
  output coord_t          pixel_x,
  output coord_t          pixel_y
);

  logic [2:0]           vld;
  logic [2:0]           rdy;
  logic [T_W-1:0]       t_sat;
  logic [T_W-1:0]       t1;
  logic [T_W-1:0]       t2;
  logic [2:0][FIX_W-1:0] l1_x;
  logic [2:0][FIX_W-1:0] l1_y;
  logic [1:0][FIX_W-1:0] l2_x;
  logic [1:0][FIX_W-1:0] l2_y;
  fix_t                 r_x;
  fix_t                 r_y;

  // a stage can take new data when it is empty or its content moves on
  assign rdy[2] = !vld[2] || result_ready;
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  assign item_ready   = rdy[0];
  assign result_valid = vld[2];

  assign t_sat = (t_param > T_ONE) ? T_ONE : t_param;
  assign r_x   = lerp_fix(l2_x[0], l2_x[1], t2);
  assign r_y   = lerp_fix(l2_y[0], l2_y[1], t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= item_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  // level one: control points to three points
  always_ff @(posedge clk) begin
    if (rdy[0] && item_valid) begin
      t1 <= t_sat;
      for (int i = 0; i < 3; i++) begin
        l1_x[i] <= lerp_fix(to_fix(pts.x[i]), to_fix(pts.x[i+1]), t_sat);
        l1_y[i] <= lerp_fix(to_fix(pts.y[i]), to_fix(pts.y[i+1]), t_sat);
      end
    end
  end

  // level two: three points to two
  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      t2 <= t1;
      for (int i = 0; i < 2; i++) begin
        l2_x[i] <= lerp_fix(l1_x[i], l1_x[i+1], t1);
        l2_y[i] <= lerp_fix(l1_y[i], l1_y[i+1], t1);
      end
    end
  end

  // level three: final point, drop the fraction
  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      pixel_x <= r_x[FIX_W-1:T_FRAC_BITS];
      pixel_y <= r_y[FIX_W-1:T_FRAC_BITS];
    end
  end

  `CBPE_ASSERT(a_accept_fills, (item_valid && item_ready) |=> vld[0], "accepted item lost at stage one")
  `CBPE_ASSERT_NEVER(a_t_range, vld[0] && (t1 > T_ONE), "stage one t above one")
  `CBPE_ASSERT(a_full_stall, ((&vld) && !result_ready) |-> !item_ready, "full stalled pipe takes input")

endmodule

// File: src/cubic_bezier_point_eval.sv
// Top level of the cubic Bezier point evaluator (de Casteljau scheme).
// Depends on cbpe_pkg, cbpe_regs and cbpe_pipe.
//
//   channel   signals                              carries
//   --------  -----------------------------------  ---------------------------
//   item      item_valid/item_ready, t_param       curve parameter, Q1.16
//   result    result_valid/result_ready, pixel_*   curve point, integer pixels
//   apb       psel/penable/pwrite/paddr/pwdata     control points p0..p3
//
// Takes one t_param transfer per cycle unless a stalled result has filled the
// pipeline; each interpolation level is a registered stage, one multiplier per lerp.
// Reset (rst, synchronous) empties the pipeline and zeroes the points.
// A stalled result holds the last stage; earlier stages advance into bubbles
// and only a full pipeline drops item_ready, so no transfer is lost or repeated.
// Write control points only while no item is in flight.

module cubic_bezier_point_eval
  import cbpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [T_W-1:0]    t_param,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y
);

  // control points from the register file into the first stage
  cbpe_points_t pts;

  cbpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pts     (pts)
  );

  // three-level interpolation pipeline
  cbpe_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .pts          (pts),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .t_param      (t_param),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y)
  );

endmodule
